### src/htlm_pkg.sv
// Package for the hierarchical tree lock manager.
// Holds operation codes, configuration register indexes, widths and the tree size. No dependencies.
package htlm_pkg;
   localparam logic [1:0] OP_LOCK    = 2'd0;
   localparam logic [1:0] OP_UNLOCK  = 2'd1;
   localparam logic [1:0] OP_UPGRADE = 2'd2;
   localparam logic [1:0] OP_INVALID = 2'd3;
   localparam logic CSR_BRANCH = 1'b0;
   localparam logic CSR_COUNT  = 1'b1;
   localparam int CSR_DATA_W = 7;
   localparam int BRANCH_W = 4;
   localparam int COUNT_W = 7;
   localparam int REQ_TYPE_W = 2;
   localparam int NODE_W = 6;
   localparam int USER_W = 16;
   localparam int MAX_NODES = 64;
endpackage

### src/hierarchical_tree_lock_manager_unit.sv
// Top level of the hierarchical tree lock manager.
// Depends on htlm_pkg for operation codes, register indexes and the tree size.
//
//  Channel | Ports                                         | Direction
//  --------+-----------------------------------------------+----------
//  request | req_valid/req_ready, req_type, node_index,    | in
//          | user_id                                       |
//  result  | rsp_valid/rsp_ready, granted                  | out
//  config  | csr_write_en, csr_index, csr_write_data       | in
//
// One request at a time runs through a small sequencer around a single
// parent-step unit (one multiply-and-shift by the branching factor per cycle).
// A lock walks the ancestors of its node to look for a held one and, if granted,
// walks them again to count it; an unlock walks them once to uncount it. An
// upgrade scans the nodes in use twice, walking up from every locked node, and
// each release walks the ancestors of the released node. After reset and after
// every register write, a clearing pass over all 64 count entries runs before a
// request is taken. A stalled result holds the block.

module hierarchical_tree_lock_manager_unit
   import htlm_pkg::*;
#(
   parameter int UID_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [REQ_TYPE_W-1:0]  req_type,
   input  logic [NODE_W-1:0]      node_index,
   input  logic [USER_W-1:0]      user_id,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   granted,
   input  logic                   csr_write_en,
   input  logic [0:0]             csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);
   localparam int IW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int UW = (UID_BITS < USER_W) ? UID_BITS : USER_W;
   localparam int RECIP_SHIFT = 10;
   localparam int PW = IW + RECIP_SHIFT + 1;

   // Sequencer states.
   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_RD      = 4'd2;
   localparam logic [3:0] ST_CHECK   = 4'd3;
   localparam logic [3:0] ST_ANC     = 4'd4;
   localparam logic [3:0] ST_ADJ     = 4'd5;
   localparam logic [3:0] ST_SCAN_RD = 4'd6;
   localparam logic [3:0] ST_SCAN_CK = 4'd7;
   localparam logic [3:0] ST_SCAN_WK = 4'd8;
   localparam logic [3:0] ST_RESP    = 4'd9;
   localparam logic [3:0] ST_ADJ_RD  = 4'd10;
   localparam logic [3:0] ST_ADJ_WR  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [BRANCH_W-1:0] branch_ff;
   logic [COUNT_W-1:0] count_ff;

   // Lock flags live in flip-flops (cleared at reset and on a register write),
   // owners and counts in memories.
   logic [MAX_NODES-1:0] flag_ff;
   logic [UW-1:0] owner_mem [MAX_NODES];
   logic [CW-1:0] cnt_mem [MAX_NODES];
   logic [UW-1:0] owner_rd_ff;
   logic [CW-1:0] cnt_rd_ff;

   logic [REQ_TYPE_W-1:0] op_ff;
   logic [IW-1:0] target_ff;
   logic [UW-1:0] uid_ff;
   logic [IW-1:0] walk_ff;             // node moving up the ancestor chain
   logic [IW-1:0] scan_ff;             // scan position for upgrade
   logic pass_ff;                      // upgrade: 0 checking, 1 releasing
   logic adj_up_ff;                    // counts go up (1) or down (0)
   logic [IW-1:0] adj_node_ff;         // node whose lock is being counted
   logic [IW-1:0] clr_ff;
   logic grant_ff;
   logic [3:0] ret_ff;                 // state after an ancestor adjust

   logic [3:0] m_eff;
   logic [CW-1:0] n_eff;
   logic [IW-1:0] pm1;
   logic [RECIP_SHIFT:0] recip;
   logic [PW-1:0] prod;
   logic [IW-1:0] parent;
   logic [IW-1:0] last_node;

   always_comb begin
      if (branch_ff == '0) m_eff = 4'd1;
      else if (branch_ff > 4'd8) m_eff = 4'd8;
      else m_eff = branch_ff;
      if (count_ff > COUNT_W'(MAX_NODES)) n_eff = CW'(MAX_NODES);
      else n_eff = CW'(count_ff);
      last_node = IW'(n_eff - 1'b1);
   end

   // Shared parent-step unit: (walk - 1) / m as a multiply by ceil(2^10 / m)
   // and a shift. The rounding error stays below one for every node index.
   always_comb begin
      unique case (m_eff)
         4'd1: recip = 11'd1024;
         4'd2: recip = 11'd512;
         4'd3: recip = 11'd342;
         4'd4: recip = 11'd256;
         4'd5: recip = 11'd205;
         4'd6: recip = 11'd171;
         4'd7: recip = 11'd147;
         default: recip = 11'd128;
      endcase
      pm1 = walk_ff - 1'b1;
      prod = PW'(pm1) * PW'(recip);
      parent = prod[RECIP_SHIFT +: IW];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign granted = grant_ff;

   // Memory ports: one read and one write address per cycle.
   logic mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [CW-1:0] cnt_wdata;
   logic own_we;
   always_comb begin
      mem_we = 1'b0;
      mem_waddr = walk_ff;
      cnt_wdata = cnt_rd_ff;
      own_we = 1'b0;
      mem_raddr = walk_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            cnt_wdata = '0;
         end
         ST_IDLE: mem_raddr = node_index[IW-1:0];
         ST_SCAN_RD: mem_raddr = scan_ff;
         ST_SCAN_CK: mem_raddr = scan_ff;
         ST_SCAN_WK: mem_raddr = scan_ff;
         ST_ADJ_RD: mem_raddr = walk_ff;
         ST_ADJ_WR: begin
            mem_we = 1'b1;
            mem_waddr = walk_ff;
            cnt_wdata = adj_up_ff ? cnt_rd_ff + 1'b1 : cnt_rd_ff - 1'b1;
         end
         default: ;
      endcase
      own_we = (state_ff == ST_ADJ && adj_up_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) cnt_mem[mem_waddr] <= cnt_wdata;
      if (own_we) owner_mem[adj_node_ff] <= uid_ff;
      cnt_rd_ff <= cnt_mem[mem_raddr];
      owner_rd_ff <= owner_mem[mem_raddr];
   end

   // Next state for the clearing and handshake states; the others are sequenced below.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == IW'(MAX_NODES - 1)) state_in = ST_IDLE;
         ST_IDLE: if (req_valid) state_in = ST_RD;
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         branch_ff <= 4'd2;
         count_ff <= 7'd64;
         flag_ff <= '0;
         clr_ff <= '0;
         grant_ff <= 1'b0;
      end else if (csr_write_en) begin
         // Register write reshapes the tree: clear all lock state.
         if (csr_index == CSR_BRANCH) branch_ff <= csr_write_data[BRANCH_W-1:0];
         else count_ff <= csr_write_data[COUNT_W-1:0];
         flag_ff <= '0;
         clr_ff <= '0;
         state_ff <= ST_CLEAR;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               state_ff <= state_in;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff <= req_type;
                  target_ff <= node_index[IW-1:0];
                  uid_ff <= user_id[UW-1:0];
                  walk_ff <= node_index[IW-1:0];
               end
               state_ff <= state_in;
            end
            ST_RD: state_ff <= ST_CHECK;
            ST_CHECK: begin
               // Data for the target is now registered.
               grant_ff <= 1'b0;
               state_ff <= ST_RESP;
               if ({{(CW-IW){1'b0}}, target_ff} < n_eff) begin
                  unique case (op_ff)
                     OP_LOCK: begin
                        if (!flag_ff[target_ff] && cnt_rd_ff == '0) begin
                           grant_ff <= 1'b1;
                           walk_ff <= target_ff;
                           state_ff <= ST_ANC;
                        end
                     end
                     OP_UNLOCK: begin
                        if (flag_ff[target_ff] && owner_rd_ff == uid_ff) begin
                           grant_ff <= 1'b1;
                           flag_ff[target_ff] <= 1'b0;
                           adj_up_ff <= 1'b0;
                           adj_node_ff <= target_ff;
                           walk_ff <= target_ff;
                           ret_ff <= ST_RESP;
                           state_ff <= ST_ADJ;
                        end
                     end
                     OP_UPGRADE: begin
                        if (!flag_ff[target_ff] && cnt_rd_ff != '0) begin
                           grant_ff <= 1'b1;
                           scan_ff <= '0;
                           pass_ff <= 1'b0;
                           state_ff <= ST_SCAN_RD;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_ANC: begin
               // Lock: walk ancestors looking for a locked one.
               if (walk_ff == '0) begin
                  if (grant_ff) begin
                     flag_ff[target_ff] <= 1'b1;
                     adj_up_ff <= 1'b1;
                     adj_node_ff <= target_ff;
                     walk_ff <= target_ff;
                     ret_ff <= ST_RESP;
                     state_ff <= ST_ADJ;
                  end else begin
                     state_ff <= ST_RESP;
                  end
               end else begin
                  walk_ff <= parent;
                  if (flag_ff[parent]) grant_ff <= 1'b0;
               end
            end
            ST_ADJ: begin
               // Owner is written this cycle when locking; start the count walk.
               if (walk_ff == '0) state_ff <= ret_ff;
               else begin
                  walk_ff <= parent;
                  state_ff <= ST_ADJ_RD;
               end
            end
            ST_ADJ_RD: state_ff <= ST_ADJ_WR;
            ST_ADJ_WR: begin
               if (walk_ff == '0) state_ff <= ret_ff;
               else begin
                  walk_ff <= parent;
                  state_ff <= ST_ADJ_RD;
               end
            end
            ST_SCAN_RD: state_ff <= ST_SCAN_CK;
            ST_SCAN_CK: begin
               walk_ff <= scan_ff;
               state_ff <= ST_SCAN_WK;
            end
            ST_SCAN_WK: begin
               // Walk up from the scanned node to see if the target is an ancestor.
               if (!flag_ff[scan_ff] || walk_ff == '0) begin
                  if (scan_ff == last_node) begin
                     if (!pass_ff) begin
                        if (grant_ff) begin
                           pass_ff <= 1'b1;
                           scan_ff <= '0;
                           state_ff <= ST_SCAN_RD;
                        end else state_ff <= ST_RESP;
                     end else begin
                        flag_ff[target_ff] <= 1'b1;
                        adj_up_ff <= 1'b1;
                        adj_node_ff <= target_ff;
                        walk_ff <= target_ff;
                        ret_ff <= ST_RESP;
                        state_ff <= ST_ADJ;
                     end
                  end else begin
                     scan_ff <= scan_ff + 1'b1;
                     state_ff <= ST_SCAN_RD;
                  end
               end else if (parent == target_ff) begin
                  if (!pass_ff) begin
                     if (owner_rd_ff != uid_ff) begin
                        grant_ff <= 1'b0;
                        state_ff <= ST_RESP;
                     end else if (scan_ff == last_node) begin
                        pass_ff <= 1'b1;
                        scan_ff <= '0;
                        state_ff <= ST_SCAN_RD;
                     end else begin
                        scan_ff <= scan_ff + 1'b1;
                        state_ff <= ST_SCAN_RD;
                     end
                  end else begin
                     // Release this descendant, then continue the scan.
                     flag_ff[scan_ff] <= 1'b0;
                     adj_up_ff <= 1'b0;
                     adj_node_ff <= scan_ff;
                     walk_ff <= scan_ff;
                     ret_ff <= (scan_ff == last_node) ? ST_SCAN_WK : ST_SCAN_RD;
                     if (scan_ff != last_node) scan_ff <= scan_ff + 1'b1;
                     state_ff <= ST_ADJ;
                  end
               end else begin
                  walk_ff <= parent;
               end
            end
            ST_RESP: state_ff <= state_in;
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

   // A waiting result holds still, and only one request is taken at a time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("took a second request while busy");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready && !rsp_valid)
      else $error("handshake active during clearing pass");
endmodule

### tb/sv/htlm_checker.sv
`timescale 1ns / 100ps
// Checker for the hierarchical tree lock manager: watches the request, result
// and configuration ports, predicts each grant and compares. Depends on htlm_pkg.
module htlm_checker
   import htlm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [REQ_TYPE_W-1:0] req_type,
   input  logic [NODE_W-1:0]     node_index,
   input  logic [USER_W-1:0]     user_id,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  granted,
   input  logic                  csr_write_en,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    fail_count,
   output int                    pending_grants,
   output int                    grant_total,
   output int                    result_total
);
   localparam int NODES = 64;

   logic [BRANCH_W-1:0] branch_reg;
   logic [COUNT_W-1:0]  count_reg;
   logic                held [NODES];
   logic [USER_W-1:0]   holder [NODES];
   int                  below [NODES];
   logic                grant_queue [$];
   logic                verdict;

   // Effective branching factor, clamped to 1..8.
   function automatic int fanout();
      if (branch_reg == 0) return 1;
      if (branch_reg > 8) return 8;
      return int'(branch_reg);
   endfunction

   function automatic int nodes_in_use();
      return (count_reg > NODES) ? NODES : int'(count_reg);
   endfunction

   function automatic void clear_tree();
      for (int k = 0; k < NODES; k++) begin
         held[k] = 1'b0;
         holder[k] = '0;
         below[k] = 0;
      end
   endfunction

   function automatic void bump_ancestors(int j, int delta);
      int m;
      m = fanout();
      while (j > 0) begin
         j = (j - 1) / m;
         below[j] += delta;
      end
   endfunction

   function automatic bit ancestor_held(int j);
      int m;
      m = fanout();
      while (j > 0) begin
         j = (j - 1) / m;
         if (held[j]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit descends_from(int a, int j);
      int m;
      m = fanout();
      while (j > 0) begin
         j = (j - 1) / m;
         if (j == a) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void take_node(int i, logic [USER_W-1:0] uid);
      held[i] = 1'b1;
      holder[i] = uid;
      bump_ancestors(i, 1);
   endfunction

   function automatic void drop_node(int i);
      bump_ancestors(i, -1);
      held[i] = 1'b0;
      holder[i] = '0;
   endfunction

   // Applies one request to the tree copy and returns whether it is granted.
   function automatic logic arbitrate(logic [1:0] op, int i, logic [USER_W-1:0] uid);
      int n;
      n = nodes_in_use();
      if (i >= n) return 1'b0;
      case (op)
         OP_LOCK: begin
            if (held[i] || below[i] != 0 || ancestor_held(i)) return 1'b0;
            take_node(i, uid);
            return 1'b1;
         end
         OP_UNLOCK: begin
            if (!held[i] || holder[i] != uid) return 1'b0;
            drop_node(i);
            return 1'b1;
         end
         OP_UPGRADE: begin
            if (held[i] || below[i] == 0) return 1'b0;
            for (int j = 0; j < n; j++)
               if (held[j] && descends_from(i, j) && holder[j] != uid) return 1'b0;
            for (int j = 0; j < n; j++)
               if (held[j] && descends_from(i, j)) drop_node(j);
            take_node(i, uid);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   assign pending_grants = grant_queue.size();

   always @(posedge clock) begin
      if (reset) begin
         branch_reg = 4'd2;
         count_reg = 7'd64;
         clear_tree();
         grant_queue.delete();
         fail_count <= 0;
         grant_total <= 0;
         result_total <= 0;
      end else begin
         // Register writes reshape the tree and drop every lock.
         if (csr_write_en) begin
            if (csr_index == CSR_BRANCH) branch_reg = csr_write_data[BRANCH_W-1:0];
            else count_reg = csr_write_data[COUNT_W-1:0];
            clear_tree();
         end
         // Predict on each request transfer.
         if (req_valid && req_ready) begin
            verdict = arbitrate(req_type, int'(node_index), user_id);
            grant_queue.insert(grant_queue.size(), verdict);
         end
         // Compare each result transfer with the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            result_total <= result_total + 1;
            if (granted) grant_total <= grant_total + 1;
            if (grant_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual granted=%0b",
                        $time, granted);
               fail_count <= fail_count + 1;
            end else if (grant_queue[0] !== granted) begin
               $display("%0t: granted mismatch, expected %0b, actual %0b",
                        $time, grant_queue[0], granted);
               fail_count <= fail_count + 1;
               void'(grant_queue.pop_front());
            end else begin
               void'(grant_queue.pop_front());
            end
         end
      end
   end
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the lock manager testbench: clock, reset, request and register
// stimulus, result back-pressure and verdict. Depends on htlm_pkg and htlm_checker.
module testbench;
   import htlm_pkg::*;

   localparam int CYCLE_LIMIT = 10000000;
   localparam int LONG_HOLD = 3000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [NODE_W-1:0]     node_index;
   logic [USER_W-1:0]     user_id;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  granted;
   logic                  csr_write_en;
   logic [0:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    fail_count;
   int                    pending_grants;
   int                    grant_total;
   int                    result_total;
   int                    cycle_count = 0;
   int                    tree_size;
   logic [USER_W-1:0]     user_pool [4];

   hierarchical_tree_lock_manager_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .node_index(node_index), .user_id(user_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .granted(granted),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   htlm_checker grant_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .node_index(node_index), .user_id(user_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .granted(granted),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_grants(pending_grants),
      .grant_total(grant_total), .result_total(result_total)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Run-length guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL hierarchical_tree_lock_manager_unit");
         $finish;
      end
   end

   // Result side: random stalls per transfer, with one long hold-off early on.
   initial begin : result_sink
      int stall;
      int done_count;
      done_count = 0;
      @(negedge reset);
      forever begin
         stall = (done_count == 40) ? LONG_HOLD : $urandom_range(0, 16);
         if (done_count % 97 > 70) stall = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         done_count++;
      end
   end

   // Offers one request after a random gap; valid stays up when the gap is zero.
   task automatic offer_request(logic [1:0] op, logic [NODE_W-1:0] node,
                                logic [USER_W-1:0] uid, bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      node_index <= node;
      user_id <= uid;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Waits for the block to drain, then writes one register.
   task automatic write_register(logic [0:0] idx, logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_grants != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Mostly well-formed traffic: few users, nodes inside the tree.
   task automatic random_phase(int items);
      logic [1:0]        op;
      logic [NODE_W-1:0] node;
      logic [USER_W-1:0] uid;
      logic [1:0]        slot;
      int                pick;
      bit                burst;
      for (int k = 0; k < items; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) op = OP_LOCK;
         else if (pick < 68) op = OP_UNLOCK;
         else if (pick < 95) op = OP_UPGRADE;
         else op = OP_INVALID;
         if (tree_size > 0 && $urandom_range(0, 99) < 88)
            node = NODE_W'($urandom_range(0, tree_size - 1));
         else
            node = NODE_W'($urandom_range(0, 63));
         slot = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 99) < 90) uid = user_pool[slot];
         else uid = USER_W'($urandom);
         burst = (k % 150) > 120;
         offer_request(op, node, uid, burst);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = '0;
      node_index = '0;
      user_id = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      tree_size = 64;
      user_pool[0] = 16'h0000;
      user_pool[1] = 16'hFFFF;
      user_pool[2] = 16'h5A3C;
      user_pool[3] = 16'h0001;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed checks on the reset tree (binary, 64 nodes).
      offer_request(OP_LOCK, 6'd0, 16'h0000, 0);     // root free
      offer_request(OP_LOCK, 6'd1, 16'h0000, 0);     // ancestor held
      offer_request(OP_UNLOCK, 6'd0, 16'hFFFF, 0);   // not the owner
      offer_request(OP_UNLOCK, 6'd0, 16'h0000, 0);
      offer_request(OP_LOCK, 6'd63, 16'hFFFF, 0);    // deepest node
      offer_request(OP_LOCK, 6'd3, 16'hFFFF, 0);
      offer_request(OP_LOCK, 6'd1, 16'hFFFF, 0);     // descendant held
      offer_request(OP_UPGRADE, 6'd1, 16'h0000, 0);  // descendants held by another
      offer_request(OP_UPGRADE, 6'd1, 16'hFFFF, 0);
      offer_request(OP_UPGRADE, 6'd1, 16'hFFFF, 0);  // node itself held now
      offer_request(OP_UPGRADE, 6'd2, 16'hFFFF, 0);  // nothing locked below
      offer_request(OP_INVALID, 6'd5, 16'hFFFF, 0);  // unknown operation
      offer_request(OP_UNLOCK, 6'd1, 16'hFFFF, 0);
      offer_request(OP_LOCK, 6'd2, 16'h8000, 0);
      offer_request(OP_UNLOCK, 6'd2, 16'h0000, 0);
      offer_request(OP_UNLOCK, 6'd2, 16'h8000, 0);
      random_phase(180);

      // Chain tree, then widest fanout.
      write_register(CSR_BRANCH, 7'd1);
      random_phase(120);
      write_register(CSR_BRANCH, 7'd8);
      random_phase(140);

      // Small trees; out-of-range nodes get refused.
      write_register(CSR_COUNT, 7'd20);
      tree_size = 20;
      write_register(CSR_BRANCH, 7'd3);
      offer_request(OP_LOCK, 6'd20, 16'h0000, 0);
      offer_request(OP_LOCK, 6'd19, 16'h0000, 0);
      random_phase(160);

      // Branch zero acts as a chain; branch fifteen as eight.
      write_register(CSR_BRANCH, 7'd0);
      write_register(CSR_COUNT, 7'd10);
      tree_size = 10;
      random_phase(120);
      write_register(CSR_BRANCH, 7'd15);
      write_register(CSR_COUNT, 7'd1);
      tree_size = 1;
      random_phase(60);

      // No nodes in use: everything refused.
      write_register(CSR_COUNT, 7'd0);
      tree_size = 0;
      random_phase(40);

      // Counts above the maximum clamp to 64.
      write_register(CSR_COUNT, 7'd127);
      write_register(CSR_BRANCH, 7'd2);
      tree_size = 64;
      random_phase(150);
      write_register(CSR_COUNT, 7'd100);
      write_register(CSR_BRANCH, 7'd4);
      random_phase(150);
      write_register(CSR_COUNT, 7'd64);
      write_register(CSR_BRANCH, 7'd2);
      random_phase(130);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_grants != 0) @(posedge clock);
      repeat (500) @(posedge clock);

      $display("Covered lock, unlock, upgrade and unknown requests over %0d results",
               result_total);
      $display("(%0d granted) across fanouts 0..15 and node counts 0..127.", grant_total);
      if (fail_count == 0 && pending_grants == 0) begin
         $display("PASS hierarchical_tree_lock_manager_unit");
      end else begin
         $display("FAIL hierarchical_tree_lock_manager_unit");
      end
      $finish;
   end
endmodule

### hierarchical_tree_lock_manager_unit.f
src/htlm_pkg.sv
src/hierarchical_tree_lock_manager_unit.sv
tb/sv/htlm_checker.sv
tb/sv/testbench.sv
